// ===== hdl/hte_pkg.sv =====
// Shared constants and types of the hashed text embedding block.
package hte_pkg;

    // Geometry defaults and fixed field widths
    localparam int LANES             = 8;
    localparam int DIMENSIONS_DEF    = 256;
    localparam int BIN_WIDTH_DEF     = 24;
    localparam int VALUE_WIDTH       = 16;
    localparam int GROUP_WIDTH       = 5;

    // Hash constants
    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;

    // Weight increments, weights scaled by ten
    localparam logic signed [4:0] PAIR_ADD   = 5'sd5;
    localparam logic signed [4:0] TRIPLE_ADD = 5'sd3;
    localparam logic signed [4:0] TOKEN_ADD  = 5'sd10;

    typedef logic [VALUE_WIDTH-1:0] t_value;

    // Golden-ratio offset i * 0x9E3779B9, modulo 2^32
    function automatic logic [31:0] golden_offset(input logic [1:0] i);
        logic [31:0] r;
        case (i)
            2'd0:    r = 32'h0000_0000;
            2'd1:    r = 32'h9E37_79B9;
            2'd2:    r = 32'h3C6E_F372;
            default: r = 32'hDAA6_6D2B;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/hte_in_if.sv =====
// Input channel of the hashed text embedding block: one text word per handshake.
interface hte_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] text_byte;

    modport source (output valid, output mode, output text_byte, input ready);
    modport sink   (input valid, input mode, input text_byte, output ready);
endinterface

// ===== hdl/hte_out_if.sv =====
// Output channel of the hashed text embedding block: one group of eight bins per word.
interface hte_out_if;
    logic                             valid;
    logic                             ready;
    logic [hte_pkg::GROUP_WIDTH-1:0]  group_index;
    hte_pkg::t_value                  value_0;
    hte_pkg::t_value                  value_1;
    hte_pkg::t_value                  value_2;
    hte_pkg::t_value                  value_3;
    hte_pkg::t_value                  value_4;
    hte_pkg::t_value                  value_5;
    hte_pkg::t_value                  value_6;
    hte_pkg::t_value                  value_7;
    logic                             last_group;

    modport source (output valid, output group_index, output value_0, output value_1,
                    output value_2, output value_3, output value_4, output value_5,
                    output value_6, output value_7, output last_group, input ready);
    modport sink   (input valid, input group_index, input value_0, input value_1,
                    input value_2, input value_3, input value_4, input value_5,
                    input value_6, input value_7, input last_group, output ready);
endinterface

// ===== hdl/hte_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
module hte_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/hashed_text_embedding.sv =====
// Hashed text embedding top level: byte tokenizer, n-gram bin store and L2 normalizer.
//
// Text words enter one at a time; the block takes one word only when idle. A byte
// that starts a token only updates the token hash; a byte that continues a token
// makes one bin update, and two once the token holds two characters. Each pair or
// triple update runs its FNV hash byte by byte (S_MUL); every update then runs a
// modulo reduction (four bits per cycle) and a read-modify-write of the bin RAM. A
// separator after a token of two or more characters costs four such updates. End of
// text runs the sum of squares over every bin (S_SRD, S_SMAG, S_SSQ, S_SACC), then
// per nonzero bin a bit-serial square-root divide (one quotient bit per S_TRY and
// S_CMP pass), sends one group per accepted output word, and finally runs a clearing
// pass over the bin RAM. The same clearing pass runs after reset; no input word is
// taken during it.
module hashed_text_embedding #(
    parameter int DIMENSIONS = hte_pkg::DIMENSIONS_DEF,
    parameter int BIN_WIDTH  = hte_pkg::BIN_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hte_in_if.sink    i_in,
    hte_out_if.source o_out
);
    localparam int BW     = BIN_WIDTH;
    localparam int AW     = $clog2(DIMENSIONS);
    localparam int GROUPS = (DIMENSIONS + hte_pkg::LANES - 1) / hte_pkg::LANES;
    localparam int GW     = $clog2(GROUPS);
    localparam int SW     = 2 * BW - 1 + AW;
    localparam int PW     = SW + 34;
    localparam int QW     = hte_pkg::VALUE_WIDTH;

    // Sequencer states
    localparam logic [4:0] S_CLEAR = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_MUL   = 5'd2;
    localparam logic [4:0] S_MOD   = 5'd3;
    localparam logic [4:0] S_RD    = 5'd4;
    localparam logic [4:0] S_WR    = 5'd5;
    localparam logic [4:0] S_CHAR  = 5'd6;
    localparam logic [4:0] S_TOK   = 5'd7;
    localparam logic [4:0] S_SRD   = 5'd8;
    localparam logic [4:0] S_SMAG  = 5'd9;
    localparam logic [4:0] S_SSQ   = 5'd10;
    localparam logic [4:0] S_SACC  = 5'd11;
    localparam logic [4:0] S_LANE  = 5'd12;
    localparam logic [4:0] S_LMAG  = 5'd13;
    localparam logic [4:0] S_LSQ   = 5'd14;
    localparam logic [4:0] S_TRY   = 5'd15;
    localparam logic [4:0] S_CMP   = 5'd16;
    localparam logic [4:0] S_LFIN  = 5'd17;
    localparam logic [4:0] S_OUT   = 5'd18;

    // Bin update kinds
    localparam logic [1:0] OP_PAIR   = 2'd0;
    localparam logic [1:0] OP_TRIPLE = 2'd1;
    localparam logic [1:0] OP_TOKEN  = 2'd2;

    logic [4:0]          r_state, n_state;
    logic [AW:0]         r_k, n_k;
    logic [31:0]         r_tok_hash, n_tok_hash;
    logic [7:0]          r_p1, n_p1;
    logic [7:0]          r_p2, n_p2;
    logic [1:0]          r_len, n_len;
    logic [7:0]          r_c, n_c;
    logic [31:0]         r_acc, n_acc;
    logic [1:0]          r_bi, n_bi;
    logic [1:0]          r_op, n_op;
    logic [1:0]          r_tok_i, n_tok_i;
    logic                r_flush, n_flush;
    logic [AW:0]         r_rem, n_rem;
    logic [31:0]         r_src, n_src;
    logic [2:0]          r_mcnt, n_mcnt;
    logic signed [4:0]   r_delta, n_delta;
    logic [SW-1:0]       r_sum, n_sum;
    logic [BW-1:0]       r_mag, n_mag;
    logic                r_neg, n_neg;
    logic [2*BW-1:0]     r_sq, n_sq;
    logic [GW-1:0]       r_g, n_g;
    logic [2:0]          r_lane, n_lane;
    logic [PW-1:0]       r_t, n_t;
    logic [PW-1:0]       r_p, n_p;
    logic [PW-1:0]       r_a, n_a;
    logic [PW-1:0]       r_s2, n_s2;
    logic [PW-1:0]       r_pt, n_pt;
    logic [3:0]          r_j, n_j;
    logic [QW-1:0]       r_q, n_q;
    hte_pkg::t_value     r_val [hte_pkg::LANES];
    hte_pkg::t_value     n_val [hte_pkg::LANES];

    logic                w_we;
    logic [AW-1:0]       w_waddr;
    logic [BW-1:0]       w_wdata;
    logic [AW-1:0]       w_raddr;
    logic [BW-1:0]       w_rdata;
    logic [7:0]          w_lc;
    logic                w_alnum;
    logic [7:0]          w_mbyte;
    logic signed [BW:0]  w_addsum;
    logic [BW-1:0]       w_sat;
    logic [BW-1:0]       w_rmag;
    logic [GW+3:0]       w_idx;
    logic [PW-1:0]       w_anext;
    logic [7:0]          w_g8;

    function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] c);
        return 32'((h ^ {24'd0, c}) * hte_pkg::FNV_PRIME);
    endfunction

    // Four restoring steps of the reduction modulo DIMENSIONS
    function automatic logic [AW:0] mod_nib(input logic [AW:0] rem, input logic [3:0] nib);
        logic [AW:0] r;
        r = rem;
        for (int b = 3; b >= 0; b--) begin
            r = {r[AW-1:0], nib[b]};
            if (r >= (AW+1)'(DIMENSIONS)) begin
                r = r - (AW+1)'(DIMENSIONS);
            end
        end
        return r;
    endfunction

    hte_ram #(.WIDTH(BW), .DEPTH(DIMENSIONS)) u_bins (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Fold case and classify the incoming byte
    always_comb begin
        w_lc = i_in.text_byte;
        if (i_in.text_byte >= 8'h41 && i_in.text_byte <= 8'h5A) begin
            w_lc = i_in.text_byte + 8'd32;
        end
        w_alnum = (w_lc >= 8'h61 && w_lc <= 8'h7A) || (w_lc >= 8'h30 && w_lc <= 8'h39);
    end

    // Byte fed to the hash chain
    always_comb begin
        case (r_bi)
            2'd0:    w_mbyte = r_p2;
            2'd1:    w_mbyte = r_p1;
            default: w_mbyte = r_c;
        endcase
    end

    // Saturating bin add, bin magnitude, lane index and next root term
    always_comb begin
        w_addsum = $signed({w_rdata[BW-1], w_rdata}) + $signed({{(BW-4){r_delta[4]}}, r_delta});
        w_sat    = w_addsum[BW-1:0];
        if (w_addsum[BW] != w_addsum[BW-1]) begin
            w_sat = w_addsum[BW] ? {1'b1, {(BW-1){1'b0}}} : {1'b0, {(BW-1){1'b1}}};
        end
        w_rmag  = w_rdata[BW-1] ? (~w_rdata + 1'b1) : w_rdata;
        w_idx   = {1'b0, r_g, r_lane};
        w_anext = ((r_pt <= r_t) ? (r_a + (r_s2 << 1)) : r_a) >> 1;
    end

    // Bin RAM port control
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_rem[AW-1:0];
        w_wdata = w_sat;
        w_raddr = r_k[AW-1:0];
        unique case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_k[AW-1:0];
                w_wdata = '0;
            end
            S_RD:    w_raddr = r_rem[AW-1:0];
            S_WR:    w_we = 1'b1;
            S_LANE:  w_raddr = w_idx[AW-1:0];
            default: w_raddr = r_k[AW-1:0];
        endcase
    end

    // Sequencer
    always_comb begin
        n_state    = r_state;
        n_k        = r_k;
        n_tok_hash = r_tok_hash;
        n_p1       = r_p1;
        n_p2       = r_p2;
        n_len      = r_len;
        n_c        = r_c;
        n_acc      = r_acc;
        n_bi       = r_bi;
        n_op       = r_op;
        n_tok_i    = r_tok_i;
        n_flush    = r_flush;
        n_rem      = r_rem;
        n_src      = r_src;
        n_mcnt     = r_mcnt;
        n_delta    = r_delta;
        n_sum      = r_sum;
        n_mag      = r_mag;
        n_neg      = r_neg;
        n_sq       = r_sq;
        n_g        = r_g;
        n_lane     = r_lane;
        n_t        = r_t;
        n_p        = r_p;
        n_a        = r_a;
        n_s2       = r_s2;
        n_pt       = r_pt;
        n_j        = r_j;
        n_q        = r_q;
        n_val      = r_val;
        unique case (r_state)
            S_CLEAR: begin
                n_k = r_k + 1'b1;
                if (r_k == (AW+1)'(DIMENSIONS - 1)) begin
                    n_k     = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in.valid) begin
                    if (!i_in.mode && w_alnum) begin
                        n_c = w_lc;
                        if (r_len != 2'd0) begin
                            n_op    = OP_PAIR;
                            n_acc   = hte_pkg::FNV_BASIS;
                            n_bi    = 2'd1;
                            n_delta = hte_pkg::PAIR_ADD;
                            n_state = S_MUL;
                        end else begin
                            n_state = S_CHAR;
                        end
                    end else begin
                        n_flush = i_in.mode;
                        if (r_len >= 2'd2) begin
                            n_op    = OP_TOKEN;
                            n_tok_i = 2'd0;
                            n_state = S_TOK;
                        end else begin
                            n_tok_hash = hte_pkg::FNV_BASIS;
                            n_p1       = '0;
                            n_p2       = '0;
                            n_len      = '0;
                            n_k        = '0;
                            n_sum      = '0;
                            n_state    = i_in.mode ? S_SRD : S_IDLE;
                        end
                    end
                end
            end
            S_MUL: begin
                n_acc = fnv_step(r_acc, w_mbyte);
                n_bi  = r_bi + 1'b1;
                if (r_bi == 2'd2) begin
                    n_src   = fnv_step(r_acc, w_mbyte);
                    n_rem   = '0;
                    n_mcnt  = '0;
                    n_state = S_MOD;
                end
            end
            S_TOK: begin
                n_src   = r_tok_hash + hte_pkg::golden_offset(r_tok_i);
                n_rem   = '0;
                n_mcnt  = '0;
                n_delta = r_tok_hash[{r_tok_i, 3'b000}] ? hte_pkg::TOKEN_ADD
                                                         : -hte_pkg::TOKEN_ADD;
                n_state = S_MOD;
            end
            S_MOD: begin
                n_rem  = mod_nib(r_rem, r_src[31:28]);
                n_src  = {r_src[27:0], 4'd0};
                n_mcnt = r_mcnt + 1'b1;
                if (r_mcnt == 3'd7) begin
                    n_state = S_RD;
                end
            end
            S_RD: n_state = S_WR;
            S_WR: begin
                case (r_op)
                    OP_PAIR: begin
                        if (r_len >= 2'd2) begin
                            n_op    = OP_TRIPLE;
                            n_acc   = hte_pkg::FNV_BASIS;
                            n_bi    = 2'd0;
                            n_delta = hte_pkg::TRIPLE_ADD;
                            n_state = S_MUL;
                        end else begin
                            n_state = S_CHAR;
                        end
                    end
                    OP_TRIPLE: n_state = S_CHAR;
                    default: begin
                        n_tok_i = r_tok_i + 1'b1;
                        n_state = S_TOK;
                        if (r_tok_i == 2'd3) begin
                            n_tok_hash = hte_pkg::FNV_BASIS;
                            n_p1       = '0;
                            n_p2       = '0;
                            n_len      = '0;
                            n_k        = '0;
                            n_sum      = '0;
                            n_state    = r_flush ? S_SRD : S_IDLE;
                        end
                    end
                endcase
            end
            S_CHAR: begin
                n_tok_hash = fnv_step(r_tok_hash, r_c);
                n_p2       = r_p1;
                n_p1       = r_c;
                if (r_len != 2'd3) begin
                    n_len = r_len + 1'b1;
                end
                n_state = S_IDLE;
            end
            S_SRD:  n_state = S_SMAG;
            S_SMAG: begin
                n_mag   = w_rmag;
                n_state = S_SSQ;
            end
            S_SSQ: begin
                n_sq    = r_mag * r_mag;
                n_state = S_SACC;
            end
            S_SACC: begin
                n_sum   = r_sum + SW'(r_sq);
                n_k     = r_k + 1'b1;
                n_state = S_SRD;
                if (r_k == (AW+1)'(DIMENSIONS - 1)) begin
                    n_g     = '0;
                    n_lane  = '0;
                    n_state = S_LANE;
                end
            end
            S_LANE: begin
                if (w_idx >= (GW+4)'(DIMENSIONS) || r_sum == '0) begin
                    n_val[r_lane] = '0;
                    n_lane        = r_lane + 1'b1;
                    n_state       = (r_lane == 3'd7) ? S_OUT : S_LANE;
                end else begin
                    n_state = S_LMAG;
                end
            end
            S_LMAG: begin
                n_mag = w_rmag;
                n_neg = w_rdata[BW-1];
                if (w_rdata == '0) begin
                    n_val[r_lane] = '0;
                    n_lane        = r_lane + 1'b1;
                    n_state       = (r_lane == 3'd7) ? S_OUT : S_LANE;
                end else begin
                    n_state = S_LSQ;
                end
            end
            S_LSQ: begin
                n_t     = PW'(r_mag * r_mag) << 30;
                n_p     = '0;
                n_a     = '0;
                n_s2    = PW'(r_sum) << 30;
                n_j     = 4'd15;
                n_q     = '0;
                n_state = S_TRY;
            end
            S_TRY: begin
                n_pt    = r_p + r_a + r_s2;
                n_state = S_CMP;
            end
            S_CMP: begin
                if (r_pt <= r_t) begin
                    n_p      = r_pt;
                    n_q[r_j] = 1'b1;
                end
                n_a     = w_anext;
                n_s2    = r_s2 >> 2;
                n_j     = r_j - 1'b1;
                n_state = (r_j == 4'd0) ? S_LFIN : S_TRY;
            end
            S_LFIN: begin
                if (r_neg) begin
                    n_val[r_lane] = ~r_q + 1'b1;
                end else begin
                    n_val[r_lane] = r_q[QW-1] ? {1'b0, {(QW-1){1'b1}}} : r_q;
                end
                n_lane  = r_lane + 1'b1;
                n_state = (r_lane == 3'd7) ? S_OUT : S_LANE;
            end
            S_OUT: begin
                if (o_out.ready) begin
                    n_lane = '0;
                    if (r_g == GW'(GROUPS - 1)) begin
                        n_flush = 1'b0;
                        n_k     = '0;
                        n_state = S_CLEAR;
                    end else begin
                        n_g     = r_g + 1'b1;
                        n_state = S_LANE;
                    end
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_k        <= '0;
            r_tok_hash <= hte_pkg::FNV_BASIS;
            r_p1       <= '0;
            r_p2       <= '0;
            r_len      <= '0;
            r_flush    <= 1'b0;
            r_op       <= OP_PAIR;
            r_tok_i    <= '0;
            r_bi       <= '0;
            r_mcnt     <= '0;
            r_g        <= '0;
            r_lane     <= '0;
            r_j        <= '0;
        end else begin
            r_state    <= n_state;
            r_k        <= n_k;
            r_tok_hash <= n_tok_hash;
            r_p1       <= n_p1;
            r_p2       <= n_p2;
            r_len      <= n_len;
            r_flush    <= n_flush;
            r_op       <= n_op;
            r_tok_i    <= n_tok_i;
            r_bi       <= n_bi;
            r_mcnt     <= n_mcnt;
            r_g        <= n_g;
            r_lane     <= n_lane;
            r_j        <= n_j;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_c     <= n_c;
        r_acc   <= n_acc;
        r_rem   <= n_rem;
        r_src   <= n_src;
        r_delta <= n_delta;
        r_sum   <= n_sum;
        r_mag   <= n_mag;
        r_neg   <= n_neg;
        r_sq    <= n_sq;
        r_t     <= n_t;
        r_p     <= n_p;
        r_a     <= n_a;
        r_s2    <= n_s2;
        r_pt    <= n_pt;
        r_q     <= n_q;
        r_val   <= n_val;
    end

    // Drive the channels
    assign w_g8              = 8'(r_g);
    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = (r_state == S_OUT);
    assign o_out.group_index = w_g8[hte_pkg::GROUP_WIDTH-1:0];
    assign o_out.value_0     = r_val[0];
    assign o_out.value_1     = r_val[1];
    assign o_out.value_2     = r_val[2];
    assign o_out.value_3     = r_val[3];
    assign o_out.value_4     = r_val[4];
    assign o_out.value_5     = r_val[5];
    assign o_out.value_6     = r_val[6];
    assign o_out.value_7     = r_val[7];
    assign o_out.last_group  = (r_g == GW'(GROUPS - 1));

    // Input and output never overlap
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !o_out.valid)
        else $error("input taken while a group is pending");

    // Clearing pass writes zeros only
    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> (w_we && w_wdata == '0))
        else $error("clearing pass wrote a nonzero bin");

    // No bin write while idle
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_we)
        else $error("bin write while idle");

    // Last group hands over to the clearing pass
    a_last_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.last_group) |=> (r_state == S_CLEAR))
        else $error("no clear after last group");

    // Partial product never passes the target
    a_root_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |=> (r_p <= r_t))
        else $error("root divide overshot its target");
endmodule

// ===== test/tb_hashed_text_embedding.sv =====
// Self-checking testbench of the hashed text embedding block.
module tb_hashed_text_embedding;

    localparam int NBINS        = hte_pkg::DIMENSIONS_DEF;
    localparam int NGROUPS      = NBINS / hte_pkg::LANES;
    localparam int BIN_TOP      = (1 << (hte_pkg::BIN_WIDTH_DEF - 1)) - 1;
    localparam int BIN_BOTTOM   = -BIN_TOP - 1;
    localparam int CYCLE_CAP    = 2000000;
    localparam int DRAIN        = 600;
    localparam int HOLD_CYCLES  = 6000;
    localparam int RANDOM_UNTIL = 280;

    typedef struct {
        logic [hte_pkg::GROUP_WIDTH-1:0] group;
        hte_pkg::t_value                 lane [hte_pkg::LANES];
        logic                            last;
    } t_group_word;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    hte_in_if  in_if ();
    hte_out_if out_if ();

    hashed_text_embedding u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Shadow copy of the block state
    int          bin_count [NBINS];
    logic [31:0] word_hash;
    logic [7:0]  last_char;
    logic [7:0]  second_char;
    int          word_len;

    t_group_word pending_groups [$];
    int          errors        = 0;
    int          cycles        = 0;
    int          items_sent    = 0;
    int          stall_left    = 0;
    int          hold_requests = 0;
    int          hold_served   = 0;
    int          ready_burst   = 0;
    bit          no_idle       = 1'b0;

    function automatic logic [31:0] fnv_mix(logic [31:0] h, logic [7:0] c);
        return (h ^ {24'd0, c}) * hte_pkg::FNV_PRIME;
    endfunction

    function automatic void bump_bin(logic [31:0] h, int d);
        int v;
        v = bin_count[h % NBINS] + d;
        if (v > BIN_TOP) v = BIN_TOP;
        if (v < BIN_BOTTOM) v = BIN_BOTTOM;
        bin_count[h % NBINS] = v;
    endfunction

    function automatic void reset_word();
        word_hash   = hte_pkg::FNV_BASIS;
        last_char   = 8'd0;
        second_char = 8'd0;
        word_len    = 0;
    endfunction

    function automatic void close_word();
        logic [31:0] offset;
        if (word_len >= 2) begin
            for (int i = 0; i < 4; i++) begin
                offset = word_hash + i * 32'h9E37_79B9;
                bump_bin(offset, word_hash[8*i] ? 10 : -10);
            end
        end
        reset_word();
    endfunction

    // Largest q in 0..32768 with q*q*s <= (mag*32768)^2
    function automatic int norm_root(longint mag, logic [127:0] s);
        logic [127:0] x, target, p;
        int lo, hi, mid;
        x = 128'(mag) << 15;
        target = x * x;
        lo = 0;
        hi = 32768;
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            p = 128'(mid) * 128'(mid) * s;
            if (p <= target) lo = mid;
            else hi = mid - 1;
        end
        return lo;
    endfunction

    // Advance the shadow state by one accepted word and queue any groups it emits
    function automatic void embed_word(logic mode, logic [7:0] b);
        logic [7:0]   c;
        logic [127:0] sum_sq;
        longint       m;
        int           q;
        t_group_word  gw;
        if (!mode) begin
            c = b;
            if (c >= "A" && c <= "Z") c = c + 8'd32;
            if ((c >= "a" && c <= "z") || (c >= "0" && c <= "9")) begin
                if (word_len >= 1)
                    bump_bin(fnv_mix(fnv_mix(hte_pkg::FNV_BASIS, last_char), c), 5);
                if (word_len >= 2)
                    bump_bin(fnv_mix(fnv_mix(fnv_mix(hte_pkg::FNV_BASIS, second_char),
                                             last_char), c), 3);
                word_hash   = fnv_mix(word_hash, c);
                second_char = last_char;
                last_char   = c;
                if (word_len < 3) word_len++;
            end else begin
                close_word();
            end
            return;
        end
        close_word();
        sum_sq = '0;
        for (int k = 0; k < NBINS; k++) begin
            m = bin_count[k] < 0 ? -bin_count[k] : bin_count[k];
            sum_sq += 128'(m) * 128'(m);
        end
        for (int g = 0; g < NGROUPS; g++) begin
            gw.group = g[hte_pkg::GROUP_WIDTH-1:0];
            gw.last  = (g == NGROUPS - 1);
            for (int k = 0; k < hte_pkg::LANES; k++) begin
                q = 0;
                if (sum_sq != 0 && bin_count[g*hte_pkg::LANES+k] != 0) begin
                    m = bin_count[g*hte_pkg::LANES+k];
                    if (m < 0) q = -norm_root(-m, sum_sq);
                    else begin
                        q = norm_root(m, sum_sq);
                        if (q > 32767) q = 32767;
                    end
                end
                gw.lane[k] = q[15:0];
            end
            pending_groups = {pending_groups, gw};
        end
        foreach (bin_count[k]) bin_count[k] = 0;
        reset_word();
    endfunction

    // Offer one word, hold it until accepted, then predict
    task automatic send_word(logic mode, logic [7:0] b);
        in_if.valid     <= 1'b1;
        in_if.mode      <= mode;
        in_if.text_byte <= b;
        do @(posedge i_clk); while (!in_if.ready);
        embed_word(mode, b);
        items_sent++;
        if (!no_idle && $urandom_range(0, 4) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_word(1'b0, s[i]);
    endtask

    function automatic logic [7:0] pick_alnum();
        case ($urandom_range(0, 2))
            0:       return 8'("a") + 8'($urandom_range(0, 25));
            1:       return 8'("A") + 8'($urandom_range(0, 25));
            default: return 8'("0") + 8'($urandom_range(0, 9));
        endcase
    endfunction

    function automatic logic [7:0] pick_separator();
        case ($urandom_range(0, 3))
            0:       return 8'(" ");
            1:       return 8'($urandom_range(128, 255));
            2:       return 8'($urandom_range(0, 47));
            default: return 8'($urandom_range(58, 64));
        endcase
    endfunction

    // Text of random words, random separators, then end of text
    task automatic send_document(int words);
        for (int w = 0; w < words; w++) begin
            repeat ($urandom_range(1, 6)) send_word(1'b0, pick_alnum());
            if ($urandom_range(0, 7) == 0) send_word(1'b0, 8'($urandom_range(0, 255)));
            if (w != words - 1 || $urandom_range(0, 1)) send_word(1'b0, pick_separator());
        end
        send_word(1'b1, 8'($urandom_range(0, 255)));
    endtask

    task automatic wait_drained();
        while (pending_groups.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_word(1'b1, 8'h00);
        send_text("Az09");
        send_word(1'b0, 8'hFF);
        send_text("q");
        send_word(1'b0, 8'h00);
        send_text("ZzZ@k7[");
        send_word(1'b0, 8'h7F);
        send_text("`{/:");
        send_text("Mix");
        send_word(1'b1, 8'hFF);
        send_word(1'b1, 8'h5A);
    endtask

    task automatic test_random();
        while (items_sent < RANDOM_UNTIL) send_document($urandom_range(1, 5));
    endtask

    // Stall the receiver long enough that the block backs up its input
    task automatic test_backpressure();
        wait_drained();
        @(posedge i_clk);
        hold_requests++;
        send_text("fill the block up");
        send_word(1'b1, 8'h00);
        send_text("more words wait behind");
        send_word(1'b1, 8'h00);
    endtask

    task automatic test_tail();
        no_idle = 1'b1;
        send_document(3);
        send_document(2);
        in_if.valid <= 1'b0;
    endtask

    // Receiver readiness: long hold-off, random bursts, or always ready
    always @(posedge i_clk) begin
        if (hold_served != hold_requests) begin
            hold_served  <= hold_requests;
            stall_left   <= HOLD_CYCLES;
            out_if.ready <= 1'b0;
        end else if (stall_left > 0) begin
            out_if.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (no_idle) begin
            out_if.ready <= 1'b1;
        end else if (ready_burst > 0) begin
            out_if.ready <= 1'b0;
            ready_burst <= ready_burst - 1;
        end else if ($urandom_range(0, 7) == 0) begin
            out_if.ready <= 1'b0;
            ready_burst <= $urandom_range(0, 6);
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    // Check each accepted group against the oldest prediction
    always @(posedge i_clk) begin
        t_group_word want;
        bit bad;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_groups.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected group %0d", out_if.group_index);
            end else begin
                want = pending_groups.pop_front();
                bad = (want.group != out_if.group_index) || (want.last != out_if.last_group)
                   || (want.lane[0] != out_if.value_0) || (want.lane[1] != out_if.value_1)
                   || (want.lane[2] != out_if.value_2) || (want.lane[3] != out_if.value_3)
                   || (want.lane[4] != out_if.value_4) || (want.lane[5] != out_if.value_5)
                   || (want.lane[6] != out_if.value_6) || (want.lane[7] != out_if.value_7);
                if (bad) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("mismatch: exp g=%0d last=%0b %h %h %h %h %h %h %h %h",
                            want.group, want.last, want.lane[0], want.lane[1],
                            want.lane[2], want.lane[3], want.lane[4], want.lane[5],
                            want.lane[6], want.lane[7]);
                        $display("          act g=%0d last=%0b %h %h %h %h %h %h %h %h",
                            out_if.group_index, out_if.last_group, out_if.value_0,
                            out_if.value_1, out_if.value_2, out_if.value_3,
                            out_if.value_4, out_if.value_5, out_if.value_6,
                            out_if.value_7);
                    end
                end
            end
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        in_if.valid     = 1'b0;
        in_if.mode      = 1'b0;
        in_if.text_byte = 8'd0;
        out_if.ready    = 1'b0;
        foreach (bin_count[k]) bin_count[k] = 0;
        reset_word();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random();
        test_backpressure();
        test_tail();
        wait_drained();
        repeat (DRAIN) @(posedge i_clk);
        if (errors == 0 && pending_groups.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
